// ===== rtl/irbm_pkg.sv =====
// Shared constants, types and codes of the image rotation inverse-mapping block.
package irbm_pkg;

  // Store geometry and fixed-point format.
  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;
  localparam int unsigned FracBits  = 14;

  // Field widths fixed by the word formats.
  localparam int unsigned CoordW  = 10;
  localparam int unsigned PixW    = 8;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DimOutW = 10;
  localparam int unsigned OutDimMax = (1 << DimOutW) - 1;

  // Register reset values.
  localparam logic [CoordW-1:0] SrcWidthRst  = 10'd512;
  localparam logic [CoordW-1:0] SrcHeightRst = 10'd512;
  localparam logic [CoefW-1:0]  CosRst       = 16'd16384;
  localparam logic [CoefW-1:0]  SinRst       = 16'd0;

  // Derived datapath widths.
  localparam int unsigned MaxDim   = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int unsigned SizeW    = $clog2(MaxDim);
  localparam int unsigned ProdW    = CoefW + SizeW + 1;
  localparam int unsigned CornW    = ProdW + 1;
  localparam int unsigned SpanW    = CornW + 1;
  localparam int unsigned OffW     = (CornW > FracBits) ? (CornW - FracBits + 1) : 2;
  localparam int unsigned IdxW     = ((OffW > CoordW) ? OffW : CoordW) + 1;
  localparam int unsigned MapProdW = CoefW + IdxW;
  localparam int unsigned MapW     = MapProdW + 1;
  localparam int unsigned ColAW    = $clog2(MaxWidth);
  localparam int unsigned RowAW    = $clog2(MaxHeight);
  localparam int unsigned DimAW    = (ColAW > RowAW) ? ColAW : RowAW;
  localparam int unsigned PosW     = ((MapW - FracBits) > DimAW) ? (MapW - FracBits)
                                                                 : (DimAW + 1);
  localparam int unsigned LimW     = ((CoordW > SizeW) ? CoordW : SizeW) + 2;
  localparam int unsigned MemDepth = MaxWidth * MaxHeight;
  localparam int unsigned AddrW    = $clog2(MemDepth);

  // Result queue and settling time of the bounding-box pipeline.
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAW    = $clog2(FifoDepth);
  localparam int unsigned CredW     = $clog2(FifoDepth + 1);
  localparam int unsigned GeomLat   = 3;
  localparam int unsigned BusyW     = $clog2(GeomLat + 1);

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdRead  = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 0,
    CfgSrcHeight = 1,
    CfgCos       = 2,
    CfgSin       = 3
  } cfg_idx_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [PixW-1:0]   pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0]    pixel_out;
    logic               inside_res;
    logic [DimOutW-1:0] out_width;
    logic [DimOutW-1:0] out_height;
  } out_word_t;

  // Settled geometry handed from the box unit to the mapping pipeline.
  typedef struct packed {
    logic signed [CoefW-1:0] cos_q;
    logic signed [CoefW-1:0] sin_q;
    logic [SizeW-1:0]        w1;
    logic [SizeW-1:0]        h1;
    logic signed [OffW-1:0]  x_off;
    logic signed [OffW-1:0]  y_off;
    logic [DimOutW-1:0]      out_width;
    logic [DimOutW-1:0]      out_height;
  } geom_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  wdata;
  } ram_req_t;

endpackage

// ===== rtl/irbm_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module irbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/irbm_geom.sv =====
// Configuration registers and the three-stage bounding-box unit.
module irbm_geom (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [irbm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [irbm_pkg::CfgW-1:0]   cfg_data_i,
  output irbm_pkg::geom_t             geom_o,
  output logic                        busy_o
);
  import irbm_pkg::*;

  localparam int unsigned CornW1 = CornW + 1;
  localparam int unsigned SpanUW = SpanW + 1;
  localparam logic [SpanUW-1:0] RoundAdd = SpanUW'((64'd1 << FracBits) - 64'd1);

  // Ceiling of a nonnegative scaled span, saturated to the output field.
  function automatic logic [DimOutW-1:0] ceil_dim(input logic signed [SpanW-1:0] span);
    logic [SpanUW-1:0] rnd;
    logic [SpanUW-1:0] q;
    rnd = SpanUW'(span) + RoundAdd;
    q   = rnd >> FracBits;
    if (q > SpanUW'(OutDimMax)) begin
      return DimOutW'(OutDimMax);
    end
    return q[DimOutW-1:0];
  endfunction

  // Scaled value divided by the scale, truncated toward zero.
  function automatic logic signed [OffW-1:0] trunc_off(input logic signed [CornW-1:0] v);
    logic signed [CornW1-1:0] ve;
    logic [CornW1-1:0]        mag;
    logic [CornW1-1:0]        sh;
    ve  = CornW1'(v);
    mag = ve[CornW1-1] ? CornW1'(-ve) : CornW1'(ve);
    sh  = mag >> FracBits;
    if (ve[CornW1-1]) begin
      return -OffW'(sh);
    end
    return OffW'(sh);
  endfunction

  logic [CoordW-1:0]       src_width_q, src_height_q;
  logic signed [CoefW-1:0] cos_q, sin_q;
  logic [BusyW-1:0]        busy_q, busy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SrcWidthRst;
      src_height_q <= SrcHeightRst;
      cos_q        <= CosRst;
      sin_q        <= SinRst;
      busy_q       <= BusyW'(GeomLat);
    end else begin
      busy_q <= busy_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSrcWidth:  src_width_q  <= cfg_data_i[CoordW-1:0];
          CfgSrcHeight: src_height_q <= cfg_data_i[CoordW-1:0];
          CfgCos:       cos_q        <= cfg_data_i;
          CfgSin:       sin_q        <= cfg_data_i;
          default:      ;
        endcase
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (cfg_we_i) begin
      busy_d = BusyW'(GeomLat);
    end else if (busy_q != '0) begin
      busy_d = busy_q - BusyW'(1);
    end
  end

  assign busy_o = (busy_q != '0);

  // Stage 1: clamp the sizes and form the four corner products.
  logic [LimW-1:0]         sw, sh, w1_full, h1_full;
  logic signed [SizeW:0]   w1_s, h1_s;
  logic [SizeW-1:0]        w1_q, h1_q;
  logic signed [ProdW-1:0] pcw_d, pch_d, psw_d, psh_d;
  logic signed [ProdW-1:0] pcw_q, pch_q, psw_q, psh_q;

  always_comb begin
    sw = LimW'(src_width_q);
    sh = LimW'(src_height_q);
    if (sw == '0) begin
      w1_full = '0;
    end else if (sw > LimW'(MaxWidth)) begin
      w1_full = LimW'(MaxWidth - 1);
    end else begin
      w1_full = sw - LimW'(1);
    end
    if (sh == '0) begin
      h1_full = '0;
    end else if (sh > LimW'(MaxHeight)) begin
      h1_full = LimW'(MaxHeight - 1);
    end else begin
      h1_full = sh - LimW'(1);
    end
    w1_s  = {1'b0, w1_full[SizeW-1:0]};
    h1_s  = {1'b0, h1_full[SizeW-1:0]};
    pcw_d = cos_q * w1_s;
    pch_d = cos_q * h1_s;
    psw_d = sin_q * w1_s;
    psh_d = sin_q * h1_s;
  end

  // Stage 2: corners and their extremes.
  logic signed [CornW-1:0] xc [4];
  logic signed [CornW-1:0] yc [4];
  logic signed [CornW-1:0] xmin_d, xmax_d, ymin_d, ymax_d;
  logic signed [CornW-1:0] xmin_q, xmax_q, ymin_q, ymax_q;

  always_comb begin
    xc[0] = '0;
    xc[1] = -CornW'(psh_q);
    xc[2] = CornW'(pcw_q);
    xc[3] = CornW'(pcw_q) - CornW'(psh_q);
    yc[0] = '0;
    yc[1] = CornW'(pch_q);
    yc[2] = CornW'(psw_q);
    yc[3] = CornW'(psw_q) + CornW'(pch_q);
    xmin_d = xc[0];
    xmax_d = xc[0];
    ymin_d = yc[0];
    ymax_d = yc[0];
    for (int k = 1; k < 4; k++) begin
      if (xc[k] < xmin_d) xmin_d = xc[k];
      if (xc[k] > xmax_d) xmax_d = xc[k];
      if (yc[k] < ymin_d) ymin_d = yc[k];
      if (yc[k] > ymax_d) ymax_d = yc[k];
    end
  end

  // Stage 3: offsets and output size.
  logic signed [OffW-1:0] x_off_q, y_off_q;
  logic [DimOutW-1:0]     out_w_q, out_h_q;
  logic signed [SpanW-1:0] span_x, span_y;

  assign span_x = SpanW'(xmax_q) - SpanW'(xmin_q);
  assign span_y = SpanW'(ymax_q) - SpanW'(ymin_q);

  always_ff @(posedge clk_i) begin
    w1_q    <= w1_full[SizeW-1:0];
    h1_q    <= h1_full[SizeW-1:0];
    pcw_q   <= pcw_d;
    pch_q   <= pch_d;
    psw_q   <= psw_d;
    psh_q   <= psh_d;
    xmin_q  <= xmin_d;
    xmax_q  <= xmax_d;
    ymin_q  <= ymin_d;
    ymax_q  <= ymax_d;
    x_off_q <= trunc_off(xmin_q);
    y_off_q <= trunc_off(ymin_q);
    out_w_q <= ceil_dim(span_x);
    out_h_q <= ceil_dim(span_y);
  end

  always_comb begin
    geom_o.cos_q      = cos_q;
    geom_o.sin_q      = sin_q;
    geom_o.w1         = w1_q;
    geom_o.h1         = h1_q;
    geom_o.x_off      = x_off_q;
    geom_o.y_off      = y_off_q;
    geom_o.out_width  = out_w_q;
    geom_o.out_height = out_h_q;
  end

  busy_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (busy_q == BusyW'(GeomLat)))
    else $error("box unit not restarted after a register write");

endmodule

// ===== rtl/irbm_map.sv =====
// Inverse-mapping pipeline: offset, rotate, floor, bound and access the source store.
module irbm_map (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_take_i,
  input  irbm_pkg::in_word_t     in_word_i,
  input  irbm_pkg::geom_t        geom_i,
  output irbm_pkg::ram_req_t     ram_req_o,
  input  logic [irbm_pkg::PixW-1:0] ram_rdata_i,
  output logic                   res_valid_o,
  output irbm_pkg::out_word_t    res_word_o
);
  import irbm_pkg::*;

  // Stage 1: output position plus bounding-box offset; store address for writes.
  logic signed [IdxW-1:0] col_s, row_s, xoff_s, yoff_s;
  logic                   wr_ok_d;
  logic [AddrW-1:0]       wr_addr_d;

  always_comb begin
    col_s     = IdxW'(in_word_i.col);
    row_s     = IdxW'(in_word_i.row);
    xoff_s    = IdxW'(geom_i.x_off);
    yoff_s    = IdxW'(geom_i.y_off);
    wr_ok_d   = (LimW'(in_word_i.col) < LimW'(MaxWidth)) &&
                (LimW'(in_word_i.row) < LimW'(MaxHeight));
    wr_addr_d = AddrW'(AddrW'(in_word_i.row) * AddrW'(MaxWidth)) + AddrW'(in_word_i.col);
  end

  logic                   v1_q, v2_q, v3_q, v4_q;
  logic                   rd1_q, rd2_q, rd3_q;
  logic signed [IdxW-1:0] i1_q, j1_q;
  logic                   wok1_q, wok2_q, wok3_q;
  logic [AddrW-1:0]       wa1_q, wa2_q, wa3_q;
  logic [PixW-1:0]        pix1_q, pix2_q, pix3_q;

  // Stage 2: the four rotation products.
  logic signed [CoefW-1:0]    c_s, s_s;
  logic signed [MapProdW-1:0] ci2_q, sj2_q, si2_q, cj2_q;

  assign c_s = geom_i.cos_q;
  assign s_s = geom_i.sin_q;

  // Stage 3: sums floored to whole source positions.
  logic signed [MapW-1:0] xs, ys, xsh, ysh;
  logic signed [PosW-1:0] px3_q, py3_q;

  always_comb begin
    xs  = MapW'(ci2_q) + MapW'(sj2_q);
    ys  = MapW'(cj2_q) - MapW'(si2_q);
    xsh = xs >>> FracBits;
    ysh = ys >>> FracBits;
  end

  // Store access from stage 3.
  logic signed [PosW-1:0] w1c, h1c;
  logic                   inside3;
  logic [AddrW-1:0]       rd_addr;

  always_comb begin
    w1c     = PosW'(geom_i.w1);
    h1c     = PosW'(geom_i.h1);
    inside3 = !px3_q[PosW-1] && !py3_q[PosW-1] && (px3_q <= w1c) && (py3_q <= h1c);
    rd_addr = AddrW'(AddrW'(py3_q[RowAW-1:0]) * AddrW'(MaxWidth)) +
              AddrW'(px3_q[ColAW-1:0]);
    ram_req_o.en    = v3_q && (rd3_q ? inside3 : wok3_q);
    ram_req_o.we    = !rd3_q;
    ram_req_o.addr  = rd3_q ? rd_addr : wa3_q;
    ram_req_o.wdata = pix3_q;
  end

  logic inside4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q && rd3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd1_q     <= (in_word_i.cmd == CmdRead);
    i1_q      <= col_s + xoff_s;
    j1_q      <= row_s + yoff_s;
    wok1_q    <= wr_ok_d;
    wa1_q     <= wr_addr_d;
    pix1_q    <= in_word_i.pixel_in;
    rd2_q     <= rd1_q;
    ci2_q     <= c_s * i1_q;
    sj2_q     <= s_s * j1_q;
    si2_q     <= s_s * i1_q;
    cj2_q     <= c_s * j1_q;
    wok2_q    <= wok1_q;
    wa2_q     <= wa1_q;
    pix2_q    <= pix1_q;
    rd3_q     <= rd2_q;
    px3_q     <= PosW'(xsh);
    py3_q     <= PosW'(ysh);
    wok3_q    <= wok2_q;
    wa3_q     <= wa2_q;
    pix3_q    <= pix2_q;
    inside4_q <= inside3;
  end

  always_comb begin
    res_word_o.pixel_out  = inside4_q ? ram_rdata_i : '0;
    res_word_o.inside_res = inside4_q;
    res_word_o.out_width  = geom_i.out_width;
    res_word_o.out_height = geom_i.out_height;
  end

  assign res_valid_o = v4_q;

endmodule

// ===== rtl/irbm_fifo.sv =====
// Result queue between the mapping pipeline and the output channel.
module irbm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  irbm_pkg::out_word_t push_word_i,
  input  logic                pop_i,
  output logic                valid_o,
  output irbm_pkg::out_word_t word_o
);
  import irbm_pkg::*;

  out_word_t          mem_q [FifoDepth];
  logic [FifoAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoAW:0]    count_q;
  logic               full;

  assign full    = (count_q == (FifoAW + 1)'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoAW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FifoAW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FifoAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full || pop_i))
    else $error("result queue written while full");

endmodule

// ===== rtl/image_rotate_backward_map.sv =====
// Read path: an accepted read word passes mapping stages 1 to 3, the registered store
// read and the result queue before it is offered on the output. Throughput: one word
// per cycle, set by the single source-memory port taking one access (pixel write or
// pixel read) per cycle; a credit limit of eight reads stalls input. Reset: registers
// return to 512 x 512, cosine 1.0 and sine 0; the input stalls while the bounding box
// settles, and again after every register write. The source memory is not cleared.
module image_rotate_backward_map (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  irbm_pkg::in_word_t           in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output irbm_pkg::out_word_t          out_word_o,
  input  logic                         cfg_we_i,
  input  logic [irbm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [irbm_pkg::CfgW-1:0]    cfg_data_i
);
  import irbm_pkg::*;

  // The box unit holds the configuration and derives offsets, clamped sizes and the
  // output size from it. While it settles it raises busy, and no word is taken.
  geom_t geom;
  logic  busy;

  irbm_geom u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom),
    .busy_o     (busy)
  );

  // Every read word reserves a place in the result queue when it is accepted, so the
  // pipeline never has to stop: the credit count covers the words in flight plus those
  // waiting in the queue. Writes take no credit since they make no result.
  logic             in_take, out_take;
  logic [CredW-1:0] cred_q, cred_d;

  assign in_stall_o = busy || (cred_q >= CredW'(FifoDepth));
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;

  always_comb begin
    cred_d = cred_q;
    if (in_take && (in_word_i.cmd == CmdRead) && !out_take) begin
      cred_d = cred_q + CredW'(1);
    end else if (out_take && !(in_take && (in_word_i.cmd == CmdRead))) begin
      cred_d = cred_q - CredW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
    end else begin
      cred_q <= cred_d;
    end
  end

  // Mapping pipeline. Writes and reads travel the same stages, so each memory access
  // happens in acceptance order and a read always sees every earlier write.
  ram_req_t        ram_req;
  logic [PixW-1:0] ram_rdata;
  logic            res_valid;
  out_word_t       res_word;

  irbm_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .in_word_i   (in_word_i),
    .geom_i      (geom),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  // Source image store, one byte per pixel at row times the store width plus column.
  irbm_ram #(
    .Width (PixW),
    .Depth (MemDepth)
  ) u_src_ram (
    .clk_i   (clk_i),
    .en_i    (ram_req.en),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  // Result queue; its head drives the output channel directly.
  irbm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_word_i (res_word),
    .pop_i       (out_take),
    .valid_o     (out_valid_o),
    .word_o      (out_word_o)
  );

  credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= CredW'(FifoDepth))
    else $error("read credit count beyond queue depth");

  output_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cred_q != '0))
    else $error("result offered without an outstanding read");

  stall_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken before the bounding box settled");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the image rotation inverse-mapping block.
module tb;
  import irbm_pkg::*;

  // Generous cycle budget: even the slowest legal run (every read stalled by a busy receiver,
  // every word delayed by an idle sender, plus reset and register settling) stays far below it.
  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldCycles    = 90;

  // The scoreboard keeps its own copy of the registers, the derived bounding box and the
  // source store. Every accepted input word updates it, and every accepted read produces one
  // expected result word that waits in a queue until the block returns its result.
  class rotation_scoreboard;
    logic [CoordW-1:0]       width_r;
    logic [CoordW-1:0]       height_r;
    logic signed [CoefW-1:0] cos_r;
    logic signed [CoefW-1:0] sin_r;
    longint                  c;
    longint                  s;
    longint                  w0;
    longint                  h0;
    longint                  x_off;
    longint                  y_off;
    logic [DimOutW-1:0]      out_w;
    logic [DimOutW-1:0]      out_h;
    bit [PixW-1:0]           image_mem [MemDepth];
    bit                      written [MemDepth];
    out_word_t               expected_q [$];
    int unsigned             errors;
    int unsigned             results_seen;
    int unsigned             inside_hits;

    function new();
      width_r  = SrcWidthRst;
      height_r = SrcHeightRst;
      cos_r    = CosRst;
      sin_r    = SinRst;
      update_box();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        CfgSrcWidth: begin
          width_r = data[CoordW-1:0];
        end
        CfgSrcHeight: begin
          height_r = data[CoordW-1:0];
        end
        CfgCos: begin
          cos_r = data;
        end
        CfgSin: begin
          sin_r = data;
        end
        default: begin
        end
      endcase
      update_box();
    endfunction

    // Ceiling of a scaled span, clipped to what the size fields can carry.
    function logic [DimOutW-1:0] span_ceil(longint span);
      longint q;
      q = (span + (longint'(1) << FracBits) - 1) >>> FracBits;
      return (q > OutDimMax) ? DimOutW'(OutDimMax) : DimOutW'(q);
    endfunction

    // Rotates the four source corners, takes the box around them and derives the offsets
    // (truncated toward zero) and the output size (rounded up).
    function void update_box();
      longint xc [4];
      longint yc [4];
      longint xmin;
      longint xmax;
      longint ymin;
      longint ymax;
      c  = cos_r;
      s  = sin_r;
      w0 = (width_r == 0) ? 1 : ((width_r > MaxWidth) ? MaxWidth : width_r);
      h0 = (height_r == 0) ? 1 : ((height_r > MaxHeight) ? MaxHeight : height_r);
      xc = '{0, -s * (h0 - 1), c * (w0 - 1), c * (w0 - 1) - s * (h0 - 1)};
      yc = '{0, c * (h0 - 1), s * (w0 - 1), s * (w0 - 1) + c * (h0 - 1)};
      xmin = xc[0];
      xmax = xc[0];
      ymin = yc[0];
      ymax = yc[0];
      for (int k = 1; k < 4; k++) begin
        if (xc[k] < xmin) xmin = xc[k];
        if (xc[k] > xmax) xmax = xc[k];
        if (yc[k] < ymin) ymin = yc[k];
        if (yc[k] > ymax) ymax = yc[k];
      end
      x_off = xmin / (longint'(1) << FracBits);
      y_off = ymin / (longint'(1) << FracBits);
      out_w = span_ceil(xmax - xmin);
      out_h = span_ceil(ymax - ymin);
    endfunction

    // Inverse rotation of one output position; the arithmetic shift floors the result.
    function void map_point(logic [CoordW-1:0] col, logic [CoordW-1:0] row,
                            output longint px, output longint py, output bit hit);
      longint i;
      longint j;
      i   = longint'(col) + x_off;
      j   = longint'(row) + y_off;
      px  = (c * i + s * j) >>> FracBits;
      py  = (c * j - s * i) >>> FracBits;
      hit = (px >= 0) && (py >= 0) && (px < w0) && (py < h0);
    endfunction

    function bit is_written(longint px, longint py);
      return written[py * MaxWidth + px];
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(in_word_t w);
      longint    px;
      longint    py;
      bit        hit;
      out_word_t e;
      if (w.cmd == CmdWrite) begin
        // Writes outside the store are dropped; writes past the configured size are kept.
        if (w.col < MaxWidth && w.row < MaxHeight) begin
          image_mem[w.row * MaxWidth + w.col] = w.pixel_in;
          written[w.row * MaxWidth + w.col]   = 1'b1;
        end
        return;
      end
      map_point(w.col, w.row, px, py, hit);
      e.pixel_out  = hit ? image_mem[py * MaxWidth + px] : '0;
      e.inside_res = hit;
      e.out_width  = out_w;
      e.out_height = out_h;
      if (hit) inside_hits++;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending, expected none, got %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      results_seen++;
      compare_field("pixel_out", e.pixel_out, got.pixel_out);
      compare_field("inside_res", e.inside_res, got.inside_res);
      compare_field("out_width", e.out_width, got.out_width);
      compare_field("out_height", e.out_height, got.out_height);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx   = CfgSrcWidth;
  logic [CfgW-1:0]       cfg_data  = '0;

  rotation_scoreboard    sb;
  int unsigned           send_idle_pct = 11;
  int unsigned           recv_idle_pct = 88;
  logic                  hold_req  = 1'b0;
  logic                  hold_used = 1'b0;
  int unsigned           hold_left = 0;
  int unsigned           cycles    = 0;
  int unsigned           n_writes  = 0;
  int unsigned           n_reads   = 0;
  logic [CfgW-1:0]       phase_regs [NumPhases][4];

  image_rotate_backward_map dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results still pending", $time, cycles,
               sb.pending());
      $display("FAIL image_rotate_backward_map");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the edge, before this edge's updates land, so the
  // check sees exactly the word and stall value that the block saw. A hold request from the
  // stimulus makes the receiver refuse words for a long stretch so that the result queue
  // inside the block fills up and its input backs up. The request is served once.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HoldCycles;
      hold_used <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one word, with a random number of idle cycles in front of it, and returns at the
  // edge that accepts it. Valid stays high on return so back-to-back words need no gap.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    if (w.cmd == CmdWrite) n_writes++;
    else n_reads++;
  endtask

  task automatic write_at(logic [CoordW-1:0] col, logic [CoordW-1:0] row,
                          logic [PixW-1:0] pix);
    in_word_t w;
    w.cmd      = CmdWrite;
    w.col      = col;
    w.row      = row;
    w.pixel_in = pix;
    send_word(w);
  endtask

  // A read that would land on a source pixel never stored is preceded by a write of that
  // pixel, so every read stays within the defined behavior of the store.
  task automatic read_at(logic [CoordW-1:0] col, logic [CoordW-1:0] row);
    longint   px;
    longint   py;
    bit       hit;
    in_word_t w;
    sb.map_point(col, row, px, py, hit);
    if (hit && !sb.is_written(px, py)) begin
      write_at(CoordW'(px), CoordW'(py), PixW'($urandom));
    end
    w.cmd      = CmdRead;
    w.col      = col;
    w.row      = row;
    w.pixel_in = PixW'($urandom);
    send_word(w);
  endtask

  // Mostly a coordinate within the span of interest, now and then any 10-bit value.
  function automatic logic [CoordW-1:0] pick_coord(longint span);
    int unsigned lim;
    if ($urandom_range(9) == 0) return CoordW'($urandom);
    lim = (span > 1023) ? 1023 : ((span < 0) ? 0 : int'(span));
    return CoordW'($urandom_range(lim));
  endfunction

  task automatic random_item();
    if ($urandom_range(99) < 40) begin
      write_at(pick_coord(sb.w0 - 1), pick_coord(sb.h0 - 1), PixW'($urandom));
    end else begin
      read_at(pick_coord(longint'(sb.out_w) + 2), pick_coord(longint'(sb.out_h) + 2));
    end
  endtask

  // Stops offering words and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Loads all four registers on consecutive edges. Only called once the block is idle: the
  // extra cycles cover a write still on its way to the store when the last result left.
  task automatic load_regs(logic [CfgW-1:0] vals [4]);
    cfg_idx_e order [4];
    order = '{CfgSrcWidth, CfgSrcHeight, CfgCos, CfgSin};
    drain();
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    for (int r = 0; r < 4; r++) begin
      cfg_idx  <= order[r];
      cfg_data <= vals[r];
      @(posedge clk);
      sb.set_reg(order[r], vals[r]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();

    // Register settings per phase. Phase 0 runs on the reset values. The size registers see
    // zero (acts as one), values past the store (act as the maximum) and junk in the upper
    // data bits; the coefficients see quarter and half turns, an oblique angle and the full
    // 16-bit extremes, which scale as well as rotate.
    phase_regs[0] = '{16'd512, 16'd512, 16'd16384, 16'd0};
    phase_regs[1] = '{16'd0, 16'd1023, 16'd16384, 16'd0};
    phase_regs[2] = '{16'd512, 16'd512, 16'd0, 16'd16384};
    phase_regs[3] = '{16'hFC01, 16'hFC01, 16'hC000, 16'd0};
    phase_regs[4] = '{16'd100, 16'd37, 16'd11585, 16'd11585};
    phase_regs[5] = '{16'd700, 16'd0, 16'd0, 16'hC000};
    phase_regs[6] = '{CfgW'($urandom_range(64, 1)), CfgW'($urandom_range(64, 1)),
                      16'h8000, 16'h7FFF};
    phase_regs[7] = '{CfgW'($urandom), CfgW'($urandom), CfgW'($urandom), CfgW'($urandom)};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on the identity setting: store corners and an interior pixel, writes
    // that fall outside the store and must be dropped, reads of those pixels, reads past
    // the source that must come back as zero and outside, and one read that needs a fill.
    write_at(10'd0, 10'd0, 8'h00);
    write_at(10'd511, 10'd511, 8'hFF);
    write_at(10'd3, 10'd7, 8'hA5);
    write_at(10'd1023, 10'd1023, 8'h5A);
    write_at(10'd512, 10'd0, 8'h3C);
    write_at(10'd0, 10'd512, 8'hC3);
    read_at(10'd0, 10'd0);
    read_at(10'd511, 10'd511);
    read_at(10'd3, 10'd7);
    read_at(10'd1023, 10'd1023);
    read_at(10'd512, 10'd0);
    read_at(10'd0, 10'd512);
    read_at(10'd511, 10'd0);
    write_at(10'd3, 10'd7, 8'h5A);
    read_at(10'd3, 10'd7);

    for (int p = 0; p < NumPhases; p++) begin
      // A slow receiver first, then a slow sender, then both at full rate.
      if (p == 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 11;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) load_regs(phase_regs[p]);
      // With both sides at full rate, a long receiver hold-off backs the block up.
      if (p == 6) hold_req <= 1'b1;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        // Halfway through one phase the sender stops until the block is empty.
        if (p == 4 && k == ItemsPerPhase / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d pixel writes and %0d reads over %0d register settings.",
             n_writes, n_reads, NumPhases);
    $display("Checked %0d result words, %0d of them inside the source image.",
             sb.results_seen, sb.inside_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS image_rotate_backward_map");
    end else begin
      $display("%0d mismatches, %0d results never returned", sb.errors, sb.pending());
      $display("FAIL image_rotate_backward_map");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/irbm_pkg.sv
rtl/irbm_ram.sv
rtl/irbm_geom.sv
rtl/irbm_map.sv
rtl/irbm_fifo.sv
rtl/image_rotate_backward_map.sv
test/tb.sv
